@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL modules of the work-stealing deque.
// Self-contained; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ hw/rtl/wsd_pkg.sv @@
// Shared types and constants for the work-stealing deque.
// No dependencies.
package wsd_pkg;

    localparam int DEPTH_DEF = 1024;

    localparam int KIND_W   = 2;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int SEEN_W   = 12;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TAKE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture request fields
        logic exec;   // apply request to indexes and store
    } t_cmd;

endpackage

@@ hw/rtl/wsd_ctrl.sv @@
// Controller state machine of the work-stealing deque: accept, execute, respond.
// Depends on wsd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_done,
    output wsd_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_done, n_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC:  n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        n_busy = (n_state != S_IDLE);
        n_done = (n_state == S_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    assign o_cmd.load = start && !r_busy;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign busy       = r_busy;
    assign o_done     = r_done;

    `ASSERT_CLK(a_accept_goes_busy, i_clk, i_rst_n, (start && !r_busy) |=> (r_busy && !r_done))
    `ASSERT_CLK(a_done_one_cycle, i_clk, i_rst_n, r_done |=> !r_done)
    `ASSERT_CLK(a_done_after_exec, i_clk, i_rst_n, r_done |-> ($past(o_cmd.exec) && r_busy))
    `ASSERT_NEVER(a_busy_matches_state, i_clk, i_rst_n, r_busy != (r_state != S_IDLE))

endmodule

@@ hw/rtl/wsd_dp.sv @@
// Datapath of the work-stealing deque: top/bottom indexes, task store, result registers.
// Depends on wsd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsd_dp #(
    parameter int DEPTH = wsd_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wsd_pkg::t_cmd                     i_cmd,
    input  logic [wsd_pkg::KIND_W-1:0]        i_kind,
    input  logic [wsd_pkg::HANDLE_W-1:0]      i_task_handle,
    output logic [wsd_pkg::STATUS_W-1:0]      o_status,
    output logic [wsd_pkg::HANDLE_W-1:0]      o_removed_task,
    output logic signed [wsd_pkg::SEEN_W-1:0] o_seen_count,
    output logic                              o_now_empty
);

    // indexes run modulo 2*DEPTH so a full queue differs from an empty one
    localparam int SPAN = 2 * DEPTH;
    localparam int IW   = $clog2(SPAN);
    localparam int AW   = $clog2(DEPTH);
    localparam logic [IW-1:0] IDX_LAST  = IW'(SPAN - 1);
    localparam logic [IW-1:0] IDX_DEPTH = IW'(DEPTH);
    localparam logic [IW:0]   SPAN_X    = (IW+1)'(SPAN);

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
        return (x == IDX_LAST) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] x);
        return (x == '0) ? IDX_LAST : x - 1'b1;
    endfunction

    function automatic logic [AW-1:0] slot_of(input logic [IW-1:0] x);
        logic [IW-1:0] s;
        s = (x >= IDX_DEPTH) ? x - IDX_DEPTH : x;
        return s[AW-1:0];
    endfunction

    logic [wsd_pkg::HANDLE_W-1:0] r_store [DEPTH];

    logic [wsd_pkg::KIND_W-1:0]   r_kind;
    logic [wsd_pkg::HANDLE_W-1:0] r_handle;
    logic [IW-1:0]                r_top, n_top;
    logic [IW-1:0]                r_bot, n_bot;
    logic [wsd_pkg::STATUS_W-1:0] r_status, n_status;
    logic [wsd_pkg::SEEN_W-1:0]   r_seen, n_seen;
    logic                         r_empty;
    logic                         r_take, n_take;
    logic [wsd_pkg::HANDLE_W-1:0] r_rd_data;

    logic [IW:0]   diff;
    logic [IW:0]   diff_wrap;
    logic [IW-1:0] count;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    always_comb begin
        diff      = {1'b0, r_bot} - {1'b0, r_top};
        diff_wrap = diff + SPAN_X;
        count     = diff[IW] ? diff_wrap[IW-1:0] : diff[IW-1:0];
    end

    always_comb begin
        n_top    = r_top;
        n_bot    = r_bot;
        n_status = wsd_pkg::ST_OK;
        n_seen   = wsd_pkg::SEEN_W'(count);
        n_take   = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = slot_of(r_bot);
        rd_addr  = slot_of(r_top);
        case (r_kind)
            wsd_pkg::KIND_PUSH: begin
                if (count >= IDX_DEPTH) begin
                    n_status = wsd_pkg::ST_FULL;
                end else begin
                    wr_en = 1'b1;
                    n_bot = idx_inc(r_bot);
                end
            end
            wsd_pkg::KIND_POP: begin
                rd_addr = slot_of(idx_dec(r_bot));
                if (count == '0) begin
                    n_status = wsd_pkg::ST_EMPTY;
                    n_seen   = '1;
                    n_bot    = r_top;
                end else if (count == IW'(1)) begin
                    // last task: top steps past it and bottom follows
                    n_take = 1'b1;
                    n_seen = '0;
                    n_top  = idx_inc(r_top);
                    n_bot  = idx_inc(r_top);
                end else begin
                    n_take = 1'b1;
                    n_seen = wsd_pkg::SEEN_W'(count - 1'b1);
                    n_bot  = idx_dec(r_bot);
                end
            end
            wsd_pkg::KIND_TAKE: begin
                if (count == '0) begin
                    n_status = wsd_pkg::ST_EMPTY;
                end else begin
                    n_take = 1'b1;
                    n_top  = idx_inc(r_top);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (wr_en) r_store[wr_addr] <= r_handle;
            r_rd_data <= r_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_handle <= i_task_handle;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_seen   <= n_seen;
            r_empty  <= (n_top == n_bot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top  <= '0;
            r_bot  <= '0;
            r_take <= 1'b0;
        end else if (i_cmd.exec) begin
            r_top  <= n_top;
            r_bot  <= n_bot;
            r_take <= n_take;
        end
    end

    assign o_status       = r_status;
    assign o_removed_task = r_take ? r_rd_data : '0;
    assign o_seen_count   = r_seen;
    assign o_now_empty    = r_empty;

    `ASSERT_NEVER(a_top_in_range, i_clk, i_rst_n, r_top > IDX_LAST)
    `ASSERT_NEVER(a_bot_in_range, i_clk, i_rst_n, r_bot > IDX_LAST)
    `ASSERT_NEVER(a_count_bounded, i_clk, i_rst_n, count > IDX_DEPTH)

endmodule

@@ hw/rtl/work_stealing_deque.sv @@
// Work-stealing deque: owner push/pop at bottom, thief take at top, fixed store.
// The result strobe o_done is registered; it rises as the controller moves from its execute state to its result state.
// A new request is accepted only in the idle state, after the execute and result states of the last one.
// Reset clears top and bottom indexes (queue empty); store contents stay undefined.
// o_done is high for one cycle only; the receiver cannot stall it.
// Depends on wsd_pkg, wsd_ctrl and wsd_dp.
module work_stealing_deque #(
    parameter int DEPTH = wsd_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [wsd_pkg::KIND_W-1:0]        i_kind,
    input  logic [wsd_pkg::HANDLE_W-1:0]      i_task_handle,
    output logic                              o_done,
    output logic [wsd_pkg::STATUS_W-1:0]      o_status,
    output logic [wsd_pkg::HANDLE_W-1:0]      o_removed_task,
    output logic signed [wsd_pkg::SEEN_W-1:0] o_seen_count,
    output logic                              o_now_empty
);

    wsd_pkg::t_cmd cmd;

    wsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    wsd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (i_kind),
        .i_task_handle  (i_task_handle),
        .o_status       (o_status),
        .o_removed_task (o_removed_task),
        .o_seen_count   (o_seen_count),
        .o_now_empty    (o_now_empty)
    );

endmodule
